// ===== src/stm_pkg.sv =====
`default_nettype none
// ============================================================================
// stm_pkg - shared types and constants of the scope sweep engine
// Command beat passed from the sample front to the result back, plus the
// fixed limits of the sweep, the re-arm and the frequency measurement.
// ============================================================================
package stm_pkg;

    // configuration register indexes
    localparam logic CFG_TIME_DIV = 1'b0;
    localparam logic CFG_VOFFSET  = 1'b1;

    // command / result kinds
    localparam logic KIND_PLOT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // sweep limits
    localparam logic [13:0] POINT_FIRST   = 14'd2;
    localparam logic [13:0] POINT_LAST    = 14'd14999;
    localparam logic [13:0] PLOT_COLS     = 14'd100;
    localparam logic [11:0] REARM_TIMEOUT = 12'd3000;
    localparam logic [7:0]  LEVEL_MAX     = 8'd255;

    // frequency = FREQ_NUM / half point index, shown below FREQ_SHOW_LIM when the time division is zero
    localparam logic [14:0] FREQ_NUM      = 15'd23000;
    localparam logic [14:0] FREQ_SHOW_LIM = 15'd10000;
    localparam int          DIV_STEPS     = 15;
    localparam int          DIV_CNT_W     = $clog2(DIV_STEPS);

    // row scaling: s/5 as (s*205)>>10, exact over 8-bit samples
    localparam logic [7:0] RECIP5    = 8'd205;
    localparam logic [5:0] ROW_ZERO  = 6'd2;
    localparam logic [5:0] ROW_BIAS  = 6'd3;
    localparam logic signed [8:0] ROW_SHIFT = 9'sd5;

    // command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        PH_SWEEP = 2'b01,
        PH_REARM = 2'b10
    } t_phase;

    typedef enum logic [3:0] {
        PS_WAIT_HIGH = 4'b0001,
        PS_WAIT_LOW  = 4'b0010,
        PS_WAIT_RISE = 4'b0100,
        PS_FOUND     = 4'b1000
    } t_pstate;

    typedef struct packed {
        logic        kind;
        logic [6:0]  column;
        logic [7:0]  sample;
        logic [8:0]  max_level;
        logic [8:0]  peak_to_peak;
        logic [12:0] half;
        logic        found;
        logic        tdiv_zero;
    } t_cmd;

endpackage
`default_nettype wire

// ===== src/stm_front.sv =====
`default_nettype none
// ============================================================================
// stm_front - sample sequencer
// Takes one sample per beat, runs the sweep / re-arm phases, the period
// detector and the level tracking, and issues plot and summary commands.
// ============================================================================
module stm_front import stm_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [6:0] i_time_div,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_sample,
    output logic            o_ready,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    t_phase      r_phase, n_phase;
    t_pstate     r_pstate, n_pstate;
    logic [13:0] r_point, n_point;
    logic [6:0]  r_skip, n_skip;
    logic [7:0]  r_prev, n_prev;
    logic [7:0]  r_trig, n_trig;
    logic [7:0]  r_upper, n_upper;
    logic [7:0]  r_lower, n_lower;
    logic [12:0] r_half, n_half;
    logic        r_found, n_found;
    logic [8:0]  r_ptp, n_ptp;
    logic [11:0] r_rearm, n_rearm;

    logic        accept;
    logic        rising, above, below;
    t_pstate     ps_step;
    logic        done;
    logic        do_finish;
    logic [7:0]  fin_upper, fin_lower, fin_span;
    logic [8:0]  fin_ptp;
    logic [7:0]  trig_new;

    // stall only when the queue has no room
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // detector comparisons against previous sample and trigger level
    assign rising = r_prev < i_sample;
    assign above  = i_sample > r_trig;
    assign below  = i_sample < r_trig;

    always_comb begin
        ps_step = r_pstate;
        done    = 1'b0;
        unique case (r_pstate)
            PS_WAIT_HIGH: if (above && rising) ps_step = PS_WAIT_LOW;
            PS_WAIT_LOW:  if (below && rising) ps_step = PS_WAIT_RISE;
            PS_WAIT_RISE: begin
                if (above && rising) begin
                    ps_step = PS_FOUND;
                    done    = 1'b1;
                end
            end
            PS_FOUND:     ps_step = PS_FOUND;
            default:      ps_step = r_pstate;
        endcase
    end

    // level tracking with the point's last sample
    assign fin_upper = (r_upper < i_sample) ? i_sample : r_upper;
    assign fin_lower = (r_lower > i_sample) ? i_sample : r_lower;
    assign fin_span  = fin_upper - fin_lower;
    assign fin_ptp   = {fin_span, 1'b0};
    assign trig_new  = (fin_upper > fin_lower) ? ((fin_span >> 1) + fin_lower) : fin_upper;

    // phase sequencing
    always_comb begin
        n_phase   = r_phase;
        n_pstate  = r_pstate;
        n_point   = r_point;
        n_skip    = r_skip;
        n_prev    = r_prev;
        n_trig    = r_trig;
        n_upper   = r_upper;
        n_lower   = r_lower;
        n_half    = r_half;
        n_found   = r_found;
        n_ptp     = r_ptp;
        n_rearm   = r_rearm;
        do_finish = 1'b0;
        o_push    = 1'b0;
        o_cmd     = '0;

        if (accept) begin
            if (r_phase == PH_SWEEP) begin
                if (r_skip == 7'd0) begin
                    // trigger sample of the point
                    n_pstate = ps_step;
                    if (done) begin
                        n_half  = r_point[13:1];
                        n_found = 1'b1;
                    end
                    n_prev = i_sample;
                    if (i_time_div == 7'd0) do_finish = 1'b1;
                    else                    n_skip    = i_time_div;
                end else begin
                    n_skip = r_skip - 7'd1;
                    if (r_skip == 7'd1) do_finish = 1'b1;
                end
            end else begin
                // re-arm: wait for a period or time out
                n_rearm = r_rearm + 12'd1;
                if (done || (r_rearm > REARM_TIMEOUT)) begin
                    n_phase  = PH_SWEEP;
                    n_point  = POINT_FIRST;
                    n_skip   = 7'd0;
                    n_pstate = PS_WAIT_HIGH;
                    n_upper  = 8'd0;
                    n_lower  = LEVEL_MAX;
                    n_found  = 1'b0;
                end else begin
                    n_prev   = i_sample;
                    n_pstate = ps_step;
                end
            end
        end

        // last sample of a point
        if (do_finish) begin
            n_upper = fin_upper;
            n_lower = fin_lower;
            if (i_sample != 8'd0) n_ptp = fin_ptp;
            if (r_point < PLOT_COLS) begin
                o_push       = 1'b1;
                o_cmd.kind   = KIND_PLOT;
                o_cmd.column = r_point[6:0];
                o_cmd.sample = i_sample;
            end
            if (((r_point > PLOT_COLS) && (n_pstate == PS_FOUND)) ||
                (r_point >= POINT_LAST)) begin
                o_push             = 1'b1;
                o_cmd.kind         = KIND_SUMMARY;
                o_cmd.max_level    = {fin_upper, 1'b0};
                o_cmd.peak_to_peak = n_ptp;
                o_cmd.half         = n_half;
                o_cmd.found        = n_found;
                o_cmd.tdiv_zero    = (i_time_div == 7'd0);
                n_trig   = trig_new;
                n_phase  = PH_REARM;
                n_rearm  = 12'd0;
                n_pstate = PS_WAIT_HIGH;
                n_prev   = i_sample;
            end else begin
                n_point = r_point + 14'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SWEEP;
            r_pstate <= PS_WAIT_HIGH;
            r_point  <= POINT_FIRST;
            r_skip   <= 7'd0;
            r_prev   <= 8'd0;
            r_trig   <= 8'd0;
            r_upper  <= 8'd0;
            r_lower  <= LEVEL_MAX;
            r_half   <= 13'd0;
            r_found  <= 1'b0;
            r_ptp    <= 9'd0;
            r_rearm  <= 12'd0;
        end else begin
            r_phase  <= n_phase;
            r_pstate <= n_pstate;
            r_point  <= n_point;
            r_skip   <= n_skip;
            r_prev   <= n_prev;
            r_trig   <= n_trig;
            r_upper  <= n_upper;
            r_lower  <= n_lower;
            r_half   <= n_half;
            r_found  <= n_found;
            r_ptp    <= n_ptp;
            r_rearm  <= n_rearm;
        end
    end

    // a summary always hands over to re-arm
    a_summary_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.kind == KIND_SUMMARY) |=> (r_phase == PH_REARM))
        else $error("summary issued without entering re-arm");

    // re-arm never carries skipped samples
    a_rearm_noskip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_REARM) |-> (r_skip == 7'd0))
        else $error("skip count live during re-arm");

endmodule
`default_nettype wire

// ===== src/stm_queue.sv =====
`default_nettype none
// ============================================================================
// stm_queue - command queue
// Two-entry FIFO between the sample front and the result back.
// ============================================================================
module stm_queue import stm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_head
);

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wptr, r_rptr;
    logic [Q_AW:0]     r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_cmd;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            r_count <= r_count + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue fill level out of range");

endmodule
`default_nettype wire

// ===== src/stm_back.sv =====
`default_nettype none
// ============================================================================
// stm_back - result formatter
// Turns plot commands into registered display rows and summary commands
// into measurements, dividing for the frequency one quotient bit a cycle.
// ============================================================================
module stm_back import stm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic signed [6:0] i_voffset,
    input  wire logic              i_q_empty,
    input  wire t_cmd              i_head,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_user,
    output logic [47:0]            o_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_HOLD = 3'b100
    } t_bstate;

    t_bstate             r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [12:0]         r_div, r_rem;
    logic [14:0]         r_quo;
    logic [8:0]          r_max, r_ptp;
    logic                r_found, r_tdz;
    logic                r_valid;
    logic                r_user;
    logic [47:0]         r_data;

    logic                out_free;
    logic                load_plot, load_sum, start_div;
    logic [15:0]         prod;
    logic [5:0]          rowv;
    logic signed [8:0]   pos;
    logic [5:0]          row;
    logic [13:0]         trial;
    logic                ge;
    logic [13:0]         diff;
    logic [14:0]         freq;
    logic                shown;

    assign out_free = !r_valid || i_ready;

    // display row: s/5 + 3 + offset + 5 (s > 0), off screen maps to row 0
    assign prod = i_head.sample * RECIP5;
    assign rowv = (i_head.sample == 8'd0) ? ROW_ZERO : (prod[15:10] + ROW_BIAS);
    assign pos  = $signed({3'b000, rowv}) + $signed({{2{i_voffset[6]}}, i_voffset}) + ROW_SHIFT;
    assign row  = (!pos[8] && pos[7:6] == 2'b00) ? pos[5:0] : 6'd0;

    // restoring divide step
    assign trial = {r_rem, r_quo[14]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    assign freq  = r_found ? r_quo : 15'd0;
    assign shown = r_tdz && (freq < FREQ_SHOW_LIM);

    // sequencing
    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        load_plot = 1'b0;
        load_sum  = 1'b0;
        start_div = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (i_head.kind == KIND_SUMMARY) begin
                        o_pop     = 1'b1;
                        start_div = 1'b1;
                        n_state   = S_DIV;
                    end else if (out_free) begin
                        o_pop     = 1'b1;
                        load_plot = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (out_free) begin
                    load_sum = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // divider and summary capture
    always_ff @(posedge i_clk) begin
        if (start_div) begin
            r_div   <= i_head.half;
            r_rem   <= 13'd0;
            r_quo   <= FREQ_NUM;
            r_cnt   <= '0;
            r_max   <= i_head.max_level;
            r_ptp   <= i_head.peak_to_peak;
            r_found <= i_head.found;
            r_tdz   <= i_head.tdiv_zero;
        end else if (r_state == S_DIV) begin
            r_rem <= ge ? diff[12:0] : trial[12:0];
            r_quo <= {r_quo[13:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (load_plot) begin
            r_user <= KIND_PLOT;
            r_data <= {1'b0, 1'b0, 15'd0, 9'd0, 9'd0, row, i_head.column};
        end else if (load_sum) begin
            r_user <= KIND_SUMMARY;
            r_data <= {1'b0, shown, freq, r_ptp, r_max, 6'd0, 7'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_plot || load_sum) r_valid <= 1'b1;
            else if (i_ready)          r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_user  = r_user;
    assign o_data  = r_data;

    a_div_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_pop)
        else $error("queue popped while a summary is in progress");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_HOLD) |-> $past(r_state == S_DIV))
        else $error("summary reached output without division");

endmodule
`default_nettype wire

// ===== src/scope_trigger_sweep_measure.sv =====
`default_nettype none
// ============================================================================
// scope_trigger_sweep_measure - scope sweep engine top level
// Configuration registers, sample front, command queue and result back.
// ============================================================================
// One 8-bit sample is taken per clock whenever the two-entry command queue
// has room. A plotted point is registered at the output once at the queue
// head with the output free; an end-of-sweep summary holds the back end
// for the frequency division, one quotient bit per cycle, so the back end
// alone may stall input once per sweep, when re-arm completes at once and
// plot points follow the summary closely; result-side stalls add to this.
// There is no clearing pass after reset. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
module scope_trigger_sweep_measure import stm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [6:0]  i_cfg_wdata,
    // sample stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] sample
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [6:0] column, [12:7] row, [21:13] max_level, [30:22] peak_to_peak,
    // [45:31] frequency, [46] frequency_shown, [47] zero
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tuser    // [0] result_kind
);

    logic [6:0]        r_time_div;
    logic signed [6:0] r_voffset;

    logic q_full, q_empty, q_push, q_pop;
    t_cmd push_cmd, head_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_div <= 7'd0;
            r_voffset  <= 7'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TIME_DIV: r_time_div <= i_cfg_wdata;
                CFG_VOFFSET:  r_voffset  <= $signed(i_cfg_wdata);
                default:      r_time_div <= r_time_div;
            endcase
        end
    end

    stm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_time_div (r_time_div),
        .i_valid    (s_axis_tvalid),
        .i_sample   (s_axis_tdata),
        .o_ready    (s_axis_tready),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    stm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    stm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_voffset (r_voffset),
        .i_q_empty (q_empty),
        .i_head    (head_cmd),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_user    (m_axis_tuser),
        .o_data    (m_axis_tdata)
    );

endmodule
`default_nettype wire
